### rtl/slr_pkg.sv
// Shared types and constants for the styled line rasterizer.
// Used by every module of the block; depends on nothing.
package slr_pkg;

  localparam int COORD_W        = 6;
  localparam int ADDR_W         = 12;
  localparam int VALUE_W        = 8;
  localparam int STYLE_W        = 2;
  localparam int COUNT_W        = 32;
  localparam int ERR_W          = COORD_W + 3;
  localparam int PADDR_W        = 5;
  localparam int PDATA_W        = 32;
  localparam int FIELD_SIZE_DEF = 64;
  localparam int DASH_RUN       = 4;
  localparam int DOT_PERIOD     = 3;
  localparam int DOT_W          = $clog2(DOT_PERIOD);

  typedef struct packed {
    logic [5:0] clip_left;
    logic [5:0] clip_top;
    logic [6:0] clip_width;
    logic [6:0] clip_height;
    logic [6:0] row_pitch;
    logic [7:0] ink_level;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic signed [ERR_W-1:0] err;
  } walk_t;

  typedef struct packed {
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic                    neg_x;
    logic                    neg_y;
  } slope_t;

  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  pixel_address;
    logic [VALUE_W-1:0] pixel_value;
    logic               last_pixel;
  } pixel_t;

endpackage

### rtl/slr_cfg_regs.sv
// Configuration register file with an APB-style write and read port.
// Depends on slr_pkg for the register struct and port widths.
module slr_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slr_pkg::PADDR_W-1:0]  paddr,
  input  logic [slr_pkg::PDATA_W-1:0]  pwdata,
  output logic [slr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output slr_pkg::cfg_t                cfg
);

  typedef enum logic [2:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_WIDTH  = 3'd2,
    REG_CLIP_HEIGHT = 3'd3,
    REG_ROW_PITCH   = 3'd4,
    REG_INK_LEVEL   = 3'd5
  } reg_index_t;

  logic [2:0] index;
  logic       wr;

  assign pready = 1'b1;
  assign index  = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_left   <= 6'd0;
      cfg.clip_top    <= 6'd0;
      cfg.clip_width  <= 7'd64;
      cfg.clip_height <= 7'd64;
      cfg.row_pitch   <= 7'd64;
      cfg.ink_level   <= 8'd255;
    end else if (wr) begin
      case (index)
        REG_CLIP_LEFT:   cfg.clip_left   <= pwdata[5:0];
        REG_CLIP_TOP:    cfg.clip_top    <= pwdata[5:0];
        REG_CLIP_WIDTH:  cfg.clip_width  <= pwdata[6:0];
        REG_CLIP_HEIGHT: cfg.clip_height <= pwdata[6:0];
        REG_ROW_PITCH:   cfg.row_pitch   <= pwdata[6:0];
        REG_INK_LEVEL:   cfg.ink_level   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (index)
      REG_CLIP_LEFT:   prdata = slr_pkg::PDATA_W'(cfg.clip_left);
      REG_CLIP_TOP:    prdata = slr_pkg::PDATA_W'(cfg.clip_top);
      REG_CLIP_WIDTH:  prdata = slr_pkg::PDATA_W'(cfg.clip_width);
      REG_CLIP_HEIGHT: prdata = slr_pkg::PDATA_W'(cfg.clip_height);
      REG_ROW_PITCH:   prdata = slr_pkg::PDATA_W'(cfg.row_pitch);
      REG_INK_LEVEL:   prdata = slr_pkg::PDATA_W'(cfg.ink_level);
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/slr_step_unit.sv
// Error-term step unit: advances the walk position by one pixel.
// Depends on slr_pkg for the walk and slope structs.
module slr_step_unit (
  input  slr_pkg::walk_t  walk,
  input  slr_pkg::slope_t slope,
  output slr_pkg::walk_t  walk_next
);

  logic signed [slr_pkg::ERR_W:0]   e2;
  logic                             step_x;
  logic                             step_y;
  logic signed [slr_pkg::ERR_W-1:0] dx_term;
  logic signed [slr_pkg::ERR_W-1:0] dy_term;

  always_comb begin
    e2      = {walk.err, 1'b0};
    step_x  = e2 >= (slr_pkg::ERR_W + 1)'(slope.dy);
    step_y  = e2 <= (slr_pkg::ERR_W + 1)'(slope.dx);
    dy_term = step_x ? slr_pkg::ERR_W'(slope.dy) : slr_pkg::ERR_W'(signed'(1'b0));
    dx_term = step_y ? slr_pkg::ERR_W'(slope.dx) : slr_pkg::ERR_W'(signed'(1'b0));
    walk_next.err = walk.err + dy_term + dx_term;
    walk_next.x   = walk.x;
    walk_next.y   = walk.y;
    if (step_x) begin
      walk_next.x = slope.neg_x ? walk.x - 1'b1 : walk.x + 1'b1;
    end
    if (step_y) begin
      walk_next.y = slope.neg_y ? walk.y - 1'b1 : walk.y + 1'b1;
    end
  end

endmodule

### rtl/slr_pixel_unit.sv
// Pixel result former: framebuffer address, clip window test and line style.
// Depends on slr_pkg for the register and pixel structs.
module slr_pixel_unit (
  input  slr_pkg::cfg_t                      cfg,
  input  logic [slr_pkg::COORD_W-1:0]        x,
  input  logic [slr_pkg::COORD_W-1:0]        y,
  input  logic [slr_pkg::STYLE_W-1:0]        style,
  input  logic [slr_pkg::COUNT_W-1:0]        count,
  input  logic [slr_pkg::DOT_W-1:0]          dot_phase,
  input  logic                               last,
  output slr_pkg::pixel_t                    pixel
);

  localparam logic [slr_pkg::STYLE_W-1:0] STYLE_DASH = 2'd1;
  localparam logic [slr_pkg::STYLE_W-1:0] STYLE_DOT  = 2'd2;
  localparam int DASH_BIT = $clog2(slr_pkg::DASH_RUN);

  logic [7:0]  x_end;
  logic [7:0]  y_end;
  logic        in_window;
  logic        ink;
  logic [12:0] product;

  always_comb begin
    x_end  = {2'b00, cfg.clip_left} + {1'b0, cfg.clip_width};
    y_end  = {2'b00, cfg.clip_top} + {1'b0, cfg.clip_height};
    in_window = (x >= cfg.clip_left) && ({2'b00, x} < x_end) &&
                (y >= cfg.clip_top) && ({2'b00, y} < y_end);
    case (style)
      STYLE_DASH: ink = ~count[DASH_BIT];
      STYLE_DOT:  ink = (dot_phase == '0);
      default:    ink = 1'b1;
    endcase
    product = 13'(y) * 13'(cfg.row_pitch);
    pixel.write_enable  = ink && in_window;
    pixel.pixel_address = slr_pkg::ADDR_W'(product + 13'(x));
    pixel.pixel_value   = cfg.ink_level;
    pixel.last_pixel    = last;
  end

endmodule

### rtl/styled_line_rasterizer.sv
// Styled line rasterizer top level: sequencer, walk registers and output register.
// Depends on slr_pkg, slr_cfg_regs, slr_step_unit and slr_pixel_unit.
//
// A segment request is taken when the block is idle; the block then drops in_ready
// and walks the segment one pixel per cycle through a single error-term step unit,
// except while out_ready holds the output register full. in_ready returns as the
// last result of the segment is registered, so a new segment is taken only once
// the last one is through. Results come out in pixel order from the start point
// to the end point, one per pixel, with last_pixel set on the end point. The dash
// counter advances on every pixel but the end point and is kept across segments
// when keep_pattern is set. Configuration is written through the APB port, one
// register per word; the user must write it only while no segment is in progress,
// as the block itself does not enforce this.
module styled_line_rasterizer #(
  parameter int FIELD_SIZE = slr_pkg::FIELD_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slr_pkg::PADDR_W-1:0]   paddr,
  input  logic [slr_pkg::PDATA_W-1:0]   pwdata,
  output logic [slr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [slr_pkg::COORD_W-1:0]   start_x,
  input  logic [slr_pkg::COORD_W-1:0]   start_y,
  input  logic [slr_pkg::COORD_W-1:0]   end_x,
  input  logic [slr_pkg::COORD_W-1:0]   end_y,
  input  logic [slr_pkg::STYLE_W-1:0]   line_style,
  input  logic                          keep_pattern,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          write_enable,
  output logic [slr_pkg::ADDR_W-1:0]    pixel_address,
  output logic [slr_pkg::VALUE_W-1:0]   pixel_value,
  output logic                          last_pixel
);

  localparam int CW = slr_pkg::COORD_W;
  localparam logic [CW-1:0] COORD_MAX = CW'(FIELD_SIZE - 1);
  localparam logic [slr_pkg::DOT_W-1:0] DOT_LAST = slr_pkg::DOT_W'(slr_pkg::DOT_PERIOD - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
    clamp = (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  state_t                          state;
  slr_pkg::cfg_t                   cfg;
  slr_pkg::walk_t                  walk;
  slr_pkg::walk_t                  walk_next;
  slr_pkg::slope_t                 slope;
  slr_pkg::slope_t                 slope_next;
  slr_pkg::pixel_t                 pixel;
  slr_pkg::pixel_t                 out_pixel;
  logic [CW-1:0]                   x_end;
  logic [CW-1:0]                   y_end;
  logic [slr_pkg::STYLE_W-1:0]     style;
  logic [slr_pkg::COUNT_W-1:0]     count;
  logic [slr_pkg::DOT_W-1:0]       dot_phase;
  logic [slr_pkg::DOT_W-1:0]       dot_phase_next;
  logic [CW-1:0]                   x0;
  logic [CW-1:0]                   y0;
  logic [CW-1:0]                   x1;
  logic [CW-1:0]                   y1;
  logic                            last;
  logic                            emit;

  slr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slr_step_unit u_step (
    .walk      (walk),
    .slope     (slope),
    .walk_next (walk_next)
  );

  slr_pixel_unit u_pixel (
    .cfg       (cfg),
    .x         (walk.x),
    .y         (walk.y),
    .style     (style),
    .count     (count),
    .dot_phase (dot_phase),
    .last      (last),
    .pixel     (pixel)
  );

  always_comb begin
    x0 = clamp(start_x);
    y0 = clamp(start_y);
    x1 = clamp(end_x);
    y1 = clamp(end_y);
    slope_next.neg_x = !(x0 < x1);
    slope_next.neg_y = !(y0 < y1);
    slope_next.dx = (x1 > x0) ? signed'({1'b0, x1 - x0}) : signed'({1'b0, x0 - x1});
    slope_next.dy = (y1 > y0) ? -signed'({1'b0, y1 - y0}) : -signed'({1'b0, y0 - y1});
    last = (walk.x == x_end) && (walk.y == y_end);
    emit = (state == ST_WALK) && (!out_valid || out_ready);
    if (&count || dot_phase == DOT_LAST) begin
      dot_phase_next = '0;
    end else begin
      dot_phase_next = dot_phase + 1'b1;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dot_phase <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            walk.x   <= x0;
            walk.y   <= y0;
            walk.err <= slr_pkg::ERR_W'(slope_next.dx) + slr_pkg::ERR_W'(slope_next.dy);
            slope    <= slope_next;
            x_end    <= x1;
            y_end    <= y1;
            style    <= line_style;
            if (!keep_pattern) begin
              count     <= '0;
              dot_phase <= '0;
            end
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (emit) begin
            out_pixel <= pixel;
            if (last) begin
              state <= ST_IDLE;
            end else begin
              walk      <= walk_next;
              count     <= count + 1'b1;
              dot_phase <= dot_phase_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign write_enable  = out_pixel.write_enable;
  assign pixel_address = out_pixel.pixel_address;
  assign pixel_value   = out_pixel.pixel_value;
  assign last_pixel    = out_pixel.last_pixel;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for styled_line_rasterizer: directed and random segments
// are predicted pixel by pixel and compared with every accepted output request.
// Depends on slr_pkg and the styled_line_rasterizer RTL.
module testbench;

  import slr_pkg::*;

  typedef enum logic [STYLE_W-1:0] {
    STYLE_SOLID, STYLE_DASHED, STYLE_DOTTED, STYLE_SPARE
  } style_e;

  typedef enum int {
    REG_CLIP_LEFT, REG_CLIP_TOP, REG_CLIP_WIDTH, REG_CLIP_HEIGHT,
    REG_ROW_PITCH, REG_INK_LEVEL, REG_SPARE_6, REG_SPARE_7
  } reg_index_e;

  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int COORD_MAX      = FIELD_SIZE_DEF - 1;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic [COORD_W-1:0]   start_x;
  logic [COORD_W-1:0]   start_y;
  logic [COORD_W-1:0]   end_x;
  logic [COORD_W-1:0]   end_y;
  logic [STYLE_W-1:0]   line_style;
  logic                 keep_pattern;
  logic                 out_valid;
  logic                 out_ready;
  logic                 write_enable;
  logic [ADDR_W-1:0]    pixel_address;
  logic [VALUE_W-1:0]   pixel_value;
  logic                 last_pixel;

  cfg_t                 window_cfg;
  logic [COUNT_W-1:0]   dash_count;
  pixel_t               expected_pixels[$];
  int                   fail_count;
  int                   burst_left;
  logic [COORD_W-1:0]   pen_x;
  logic [COORD_W-1:0]   pen_y;

  styled_line_rasterizer u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .line_style    (line_style),
    .keep_pattern  (keep_pattern),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_enable  (write_enable),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .last_pixel    (last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("styled_line_rasterizer verification failed");
    $finish;
  end

  // Walks one segment with the error-term algorithm and queues its pixels.
  task automatic predict_segment(input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
                                 input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
                                 input style_e style, input logic keep);
    int     x;
    int     y;
    int     xe;
    int     ye;
    int     dx;
    int     dy;
    int     step_x;
    int     step_y;
    int     err;
    int     e2;
    int     addr;
    int     n;
    bit     at_end;
    bit     inked;
    bit     in_window;
    pixel_t px;
    x = x0;
    y = y0;
    xe = x1;
    ye = y1;
    dx = (xe > x) ? xe - x : x - xe;
    dy = -((ye > y) ? ye - y : y - ye);
    step_x = (x < xe) ? 1 : -1;
    step_y = (y < ye) ? 1 : -1;
    err = dx + dy;
    if (!keep) dash_count = '0;
    for (n = 0; n < FIELD_SIZE_DEF; n++) begin
      at_end = (x == xe) && (y == ye);
      case (style)
        STYLE_DASHED: inked = ((dash_count / DASH_RUN) % 2) == 0;
        STYLE_DOTTED: inked = (dash_count % DOT_PERIOD) == 0;
        default:      inked = 1'b1;
      endcase
      if (!at_end) dash_count = dash_count + 1'b1;
      in_window = x >= int'(window_cfg.clip_left) &&
                  x < int'(window_cfg.clip_left) + int'(window_cfg.clip_width) &&
                  y >= int'(window_cfg.clip_top) &&
                  y < int'(window_cfg.clip_top) + int'(window_cfg.clip_height);
      addr = y * int'(window_cfg.row_pitch) + x;
      px.write_enable  = inked && in_window;
      px.pixel_address = addr[ADDR_W-1:0];
      px.pixel_value   = window_cfg.ink_level;
      px.last_pixel    = at_end;
      expected_pixels.push_back(px);
      if (at_end) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x += step_x;
      end
      if (e2 <= dx) begin
        err += dx;
        y += step_y;
      end
    end
  endtask

  task automatic draw_segment(input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
                              input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
                              input style_e style, input logic keep);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    start_x      <= x0;
    start_y      <= y0;
    end_x        <= x1;
    end_y        <= y1;
    line_style   <= style;
    keep_pattern <= keep;
    do @(posedge clk); while (!in_ready);
    predict_segment(x0, y0, x1, y1, style, keep);
    pen_x = x1;
    pen_y = y1;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_e idx, input logic [PDATA_W-1:0] value);
    logic [PADDR_W-1:0] byte_addr;
    byte_addr = PADDR_W'(idx * 4);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= byte_addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CLIP_LEFT:   window_cfg.clip_left   = value[5:0];
      REG_CLIP_TOP:    window_cfg.clip_top    = value[5:0];
      REG_CLIP_WIDTH:  window_cfg.clip_width  = value[6:0];
      REG_CLIP_HEIGHT: window_cfg.clip_height = value[6:0];
      REG_ROW_PITCH:   window_cfg.row_pitch   = value[6:0];
      REG_INK_LEVEL:   window_cfg.ink_level   = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_window(input int left, input int top, input int width, input int height,
                            input int pitch, input int ink);
    write_register(REG_CLIP_LEFT, left);
    write_register(REG_CLIP_TOP, top);
    write_register(REG_CLIP_WIDTH, width);
    write_register(REG_CLIP_HEIGHT, height);
    write_register(REG_ROW_PITCH, pitch);
    write_register(REG_INK_LEVEL, ink);
  endtask

  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 12) - 6;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v[COORD_W-1:0];
  endfunction

  task automatic test_directed_shapes();
    draw_segment(0, 0, 0, 0, STYLE_SOLID, 1'b0);
    draw_segment(63, 63, 63, 63, STYLE_DASHED, 1'b0);
    draw_segment(0, 0, 63, 0, STYLE_SOLID, 1'b0);
    draw_segment(63, 63, 63, 0, STYLE_DASHED, 1'b0);
    draw_segment(0, 63, 63, 0, STYLE_DOTTED, 1'b0);
    draw_segment(10, 5, 20, 40, STYLE_SPARE, 1'b1);
    draw_segment(0, 10, 9, 10, STYLE_DASHED, 1'b0);
    draw_segment(9, 10, 9, 20, STYLE_DASHED, 1'b1);
    draw_segment(9, 20, 0, 30, STYLE_DOTTED, 1'b1);
    draw_segment(40, 2, 5, 17, STYLE_DOTTED, 1'b0);
    draw_segment(5, 60, 12, 3, STYLE_DASHED, 1'b1);
    draw_segment(42, 21, 21, 42, STYLE_SOLID, 1'b1);
  endtask

  task automatic test_clip_window();
    wait_idle();
    set_window(10, 20, 5, 7, 64, 8'h5A);
    draw_segment(0, 18, 30, 30, STYLE_SOLID, 1'b0);
    draw_segment(12, 63, 14, 0, STYLE_DASHED, 1'b1);
    wait_idle();
    set_window(0, 0, 0, 64, 64, 8'hFF);
    draw_segment(0, 0, 63, 63, STYLE_SOLID, 1'b0);
    wait_idle();
    set_window(63, 63, 127, 127, 64, 8'h00);
    draw_segment(60, 60, 63, 63, STYLE_SOLID, 1'b0);
    draw_segment(63, 0, 63, 63, STYLE_DOTTED, 1'b1);
  endtask

  task automatic test_row_pitch();
    wait_idle();
    set_window(0, 0, 64, 64, 127, 8'h81);
    draw_segment(0, 63, 63, 60, STYLE_SOLID, 1'b0);
    wait_idle();
    write_register(REG_ROW_PITCH, 1);
    draw_segment(0, 0, 17, 63, STYLE_DASHED, 1'b0);
    wait_idle();
    write_register(REG_ROW_PITCH, 0);
    draw_segment(3, 0, 3, 9, STYLE_SOLID, 1'b0);
    wait_idle();
    write_register(REG_SPARE_6, $urandom());
    write_register(REG_SPARE_7, $urandom());
    draw_segment(1, 62, 62, 1, STYLE_DOTTED, 1'b0);
  endtask

  task automatic test_random_segments(input int phases, input int per_phase);
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic               keep;
    int                 kind;
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      if (p == 0) begin
        set_window(0, 0, 64, 64, 64, 255);
      end else if (p % 3 == 0) begin
        set_window($urandom_range(0, 1) ? 63 : 0, $urandom_range(0, 1) ? 63 : 0,
                   $urandom_range(0, 1) ? 64 : 0, $urandom_range(0, 1) ? 64 : 0,
                   $urandom_range(0, 1) ? 64 : 1, $urandom_range(0, 1) ? 255 : 0);
      end else if (p % 3 == 1) begin
        set_window($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        set_window($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 64),
                   $urandom_range(0, 64), $urandom_range(1, 64), $urandom_range(0, 255));
      end
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 99) < 45) begin
          x0 = pen_x;
          y0 = pen_y;
          keep = $urandom_range(0, 9) != 0;
        end else begin
          x0 = COORD_W'($urandom_range(0, COORD_MAX));
          y0 = COORD_W'($urandom_range(0, COORD_MAX));
          keep = 1'($urandom_range(0, 1));
        end
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          x1 = near_coord(x0);
          y1 = near_coord(y0);
        end else if (kind < 90) begin
          x1 = COORD_W'($urandom_range(0, COORD_MAX));
          y1 = COORD_W'($urandom_range(0, COORD_MAX));
        end else begin
          x0 = COORD_W'($urandom_range(0, 1) ? COORD_MAX : 0);
          x1 = COORD_W'(COORD_MAX - int'(x0));
          y0 = COORD_W'($urandom_range(0, COORD_MAX));
          y1 = COORD_W'($urandom_range(0, COORD_MAX));
        end
        draw_segment(x0, y0, x1, y1, style_e'($urandom_range(0, 3)), keep);
      end
    end
  endtask

  initial begin : result_monitor
    int     stretch_left;
    int     stall_mode;
    pixel_t want;
    pixel_t got;
    out_ready <= 1'b0;
    stretch_left = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = '{write_enable, pixel_address, pixel_value, last_pixel};
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected pixel: we=%0b addr=%0d value=%0d last=%0b",
                     got.write_enable, got.pixel_address, got.pixel_value, got.last_pixel);
        end else begin
          want = expected_pixels.pop_front();
          if (got.write_enable !== want.write_enable ||
              got.pixel_address !== want.pixel_address ||
              got.pixel_value !== want.pixel_value ||
              got.last_pixel !== want.last_pixel) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("pixel mismatch: expected we=%0b addr=%0d value=%0d last=%0b,",
                       want.write_enable, want.pixel_address, want.pixel_value,
                       want.last_pixel, " got we=%0b addr=%0d value=%0d last=%0b",
                       got.write_enable, got.pixel_address, got.pixel_value,
                       got.last_pixel);
          end
        end
      end
      if (stretch_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stretch_left = $urandom_range(16, 160);
      end
      stretch_left--;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 3) != 0;
        default: out_ready <= $urandom_range(0, 5) == 0;
      endcase
    end
  end

  initial begin
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid     <= 1'b0;
    start_x      <= '0;
    start_y      <= '0;
    end_x        <= '0;
    end_y        <= '0;
    line_style   <= STYLE_SOLID;
    keep_pattern <= 1'b0;
    window_cfg   = '{clip_left: 6'd0, clip_top: 6'd0, clip_width: 7'd64,
                     clip_height: 7'd64, row_pitch: 7'd64, ink_level: 8'd255};
    dash_count   = '0;
    fail_count   = 0;
    burst_left   = 0;
    pen_x        = '0;
    pen_y        = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_shapes();
    test_clip_window();
    test_row_pitch();
    test_random_segments(8, 60);
    wait_idle();
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("styled_line_rasterizer verification clean");
    end else begin
      $display("styled_line_rasterizer verification failed");
    end
    $finish;
  end

endmodule
